// ----- hdl/oq_pkg.sv -----
// oq_pkg: sizes, operation and status codes, sequencer states and the
// storage request struct for the ordered task queue
// no dependencies
`timescale 1ns / 1ps

package oq_pkg;

	// queue geometry
	localparam int DEPTH  = 16;
	localparam int ID_W   = 8;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// fixed field widths
	localparam int LIM_W  = 5;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
	localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(16);

	// operation codes
	localparam logic [FUNC_W-1:0] FN_ENQ  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_DEQ  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_MOVE = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	// sequencer states
	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_SRCH_RD  = 6'b000010,
		S_SRCH_CMP = 6'b000100,
		S_SHF_RD   = 6'b001000,
		S_SHF_WR   = 6'b010000,
		S_REPLY    = 6'b100000
	} state_t;

	// one read and one write port request to the entry store
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [ID_W-1:0]   wr_data;
	} mem_req_t;

endpackage

// ----- hdl/oq_store.sv -----
// oq_store: entry store of the queue, one write and one registered read per cycle
// depends on oq_pkg
`timescale 1ns / 1ps

module oq_store (
	input  logic                       clk,
	input  oq_pkg::mem_req_t           req,
	output logic [oq_pkg::ID_W-1:0]    rd_data
);
	import oq_pkg::*;

	logic [ID_W-1:0] mem_q [DEPTH];
	logic [ID_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/oq_seq.sv -----
// oq_seq: sequencer that walks the entry store one entry at a time to
// search, remove and shift entries, and holds the entry count
// depends on oq_pkg
`timescale 1ns / 1ps

module oq_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [oq_pkg::FUNC_W-1:0]    func,
	input  logic [oq_pkg::ID_W-1:0]      task_id,
	input  logic [oq_pkg::CNT_W-1:0]     lim_eff,
	output logic                         busy,
	output logic                         done,
	output logic [oq_pkg::STAT_W-1:0]    status,
	output logic [oq_pkg::ID_W-1:0]      removed_id,
	output logic [oq_pkg::CNT_W-1:0]     entry_count,
	output oq_pkg::mem_req_t             mem_req,
	input  logic [oq_pkg::ID_W-1:0]      rd_data
);
	import oq_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [ADDR_W-1:0]  idx_q, idx_d;
	logic [FUNC_W-1:0]  func_q, func_d;
	logic [ID_W-1:0]    id_q, id_d;
	logic [ID_W-1:0]    taken_q, taken_d;
	logic [STAT_W-1:0]  status_q, status_d;
	logic [ID_W-1:0]    removed_q, removed_d;
	logic [CNT_W-1:0]   idx_inc;
	logic               more;

	// shared index step and compare against the count
	assign idx_inc = CNT_W'(idx_q) + CNT_W'(1);
	assign more    = (idx_inc < count_q);

	// next state and store requests
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		func_d    = func_q;
		id_d      = id_q;
		taken_d   = taken_q;
		status_d  = status_q;
		removed_d = removed_q;
		mem_req   = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					func_d    = func;
					id_d      = task_id;
					status_d  = ST_OK;
					removed_d = '0;
					idx_d     = '0;
					state_d   = S_REPLY;
					case (func)
						FN_ENQ: begin
							if (count_q >= lim_eff) begin
								status_d = ST_FULL;
							end else begin
								mem_req.wr_en   = 1'b1;
								mem_req.wr_addr = count_q[ADDR_W-1:0];
								mem_req.wr_data = task_id;
								count_d         = count_q + CNT_W'(1);
							end
						end
						FN_DEQ: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								state_d = S_SRCH_RD;
							end
						end
						FN_MOVE: begin
							if (count_q == '0) begin
								status_d = ST_NOT_FOUND;
							end else begin
								state_d = S_SRCH_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			// read the entry under the index
			S_SRCH_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = idx_q;
				state_d         = S_SRCH_CMP;
			end
			// dequeue takes the head, move takes the oldest match
			S_SRCH_CMP: begin
				if (func_q == FN_DEQ || rd_data == id_q) begin
					taken_d = rd_data;
					state_d = S_SHF_RD;
				end else if (more) begin
					idx_d   = idx_q + ADDR_W'(1);
					state_d = S_SRCH_RD;
				end else begin
					status_d = ST_NOT_FOUND;
					state_d  = S_REPLY;
				end
			end
			// fetch the next younger entry, or finish at the tail
			S_SHF_RD: begin
				if (more) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = idx_inc[ADDR_W-1:0];
					state_d         = S_SHF_WR;
				end else begin
					if (func_q == FN_DEQ) begin
						count_d   = count_q - CNT_W'(1);
						removed_d = taken_q;
					end else begin
						mem_req.wr_en   = 1'b1;
						mem_req.wr_addr = idx_q;
						mem_req.wr_data = taken_q;
					end
					state_d = S_REPLY;
				end
			end
			// move it one place toward the head
			S_SHF_WR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = idx_q;
				mem_req.wr_data = rd_data;
				idx_d           = idx_q + ADDR_W'(1);
				state_d         = S_SHF_RD;
			end
			S_REPLY: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		func_q    <= func_d;
		id_q      <= id_d;
		taken_q   <= taken_d;
		status_q  <= status_d;
		removed_q <= removed_d;
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_REPLY);
	assign status      = status_q;
	assign removed_id  = removed_q;
	assign entry_count = count_q;

endmodule

// ----- hdl/ordered_queue_move_to_tail.sv -----
// ordered_queue_move_to_tail: bounded ordered task queue with enqueue, dequeue, move-to-tail
// enqueue, unused codes and empty cases go straight from accept to the reply; dequeue and move
// read and compare each entry searched, then read and write each entry shifted
// one item at a time, busy from accept through the done cycle
// results show for one cycle on done and cannot be stalled
// async reset empties the queue and sets the limit to 16; store contents are not cleared
`timescale 1ns / 1ps

module ordered_queue_move_to_tail (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [oq_pkg::FUNC_W-1:0]    func,
	input  logic [oq_pkg::ID_W-1:0]      task_id,
	output logic                         done,
	output logic [oq_pkg::STAT_W-1:0]    status,
	output logic [oq_pkg::ID_W-1:0]      removed_id,
	output logic [oq_pkg::CNT_W-1:0]     entry_count,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [oq_pkg::LIM_W-1:0]     cfg_data
);
	import oq_pkg::*;

	logic [LIM_W-1:0] limit_q;
	logic [CNT_W-1:0] lim_eff;
	mem_req_t         mem_req;
	logic [ID_W-1:0]  rd_data;

	// capacity limit register
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// a limit above the depth acts as the depth
	assign lim_eff = (int'(limit_q) > DEPTH) ? DEPTH_CNT : CNT_W'(limit_q);

	oq_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.func        (func),
		.task_id     (task_id),
		.lim_eff     (lim_eff),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.removed_id  (removed_id),
		.entry_count (entry_count),
		.mem_req     (mem_req),
		.rd_data     (rd_data)
	);

	oq_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// count never exceeds the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= DEPTH_CNT)
		else $error("entry count above depth");

	// an enqueue replies in the next cycle
	a_enq_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FN_ENQ) |=> done)
		else $error("enqueue reply missing");

	// the count only moves into a reply cycle
	a_count_on_reply: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(entry_count) |-> done)
		else $error("count changed outside a reply");

	// one result per item
	a_single_reply: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result repeated");

endmodule
